// File: hw/rtl/utf8_stream_decoder_unit_assert.svh
// assertion macros for the utf-8 stream decoder
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UTF8D_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define UTF8D_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/utf8d_pkg.sv
// shared types, constants and decode functions for the utf-8 stream decoder
// no dependencies
`default_nettype none

package utf8d_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  len_t;
  typedef logic [20:0] cp_t;
  typedef logic [23:0] out_data_t;

  localparam byte_t LEAD4 = 8'hF0;
  localparam byte_t LEAD3 = 8'hE0;
  localparam byte_t LEAD2 = 8'hC0;

  localparam len_t LEN_NONE = 3'd0;
  localparam len_t LEN1     = 3'd1;
  localparam len_t LEN2     = 3'd2;
  localparam len_t LEN3     = 3'd3;
  localparam len_t LEN4     = 3'd4;

  function automatic len_t lead_length(input byte_t b);
    len_t n;
    if (b >= LEAD4) begin
      n = LEN4;
    end else if (b >= LEAD3) begin
      n = LEN3;
    end else if (b >= LEAD2) begin
      n = LEN2;
    end else begin
      n = LEN1;
    end
    return n;
  endfunction

  // masks per length: 0x1f, 0x0f, 0x07 on the lead, 0x3f on the rest
  function automatic cp_t decode_seq(input byte_t b0, input byte_t b1,
                                     input byte_t b2, input byte_t b3,
                                     input len_t n);
    cp_t cp;
    unique case (n)
      LEN1:    cp = {13'd0, b0};
      LEN2:    cp = {10'd0, b0[4:0], b1[5:0]};
      LEN3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/utf8_stream_decoder_unit.sv
// Lenient UTF-8 decoder: takes one byte per cycle unless the output stalls, and gives
// one code point per completed sequence. The lead byte sets the length (0xF0 and up 4,
// 0xE0 3, 0xC0 2, else 1), the following bytes are taken unchecked, and a buffer end
// (s_tlast) closes the sequence early with the formula for the bytes held. Throughput
// is one byte per cycle with no bubbles while unstalled; an accepted byte passes through
// the input register and is decoded into the result register. A waiting result stalls
// the input only when the byte in the input register completes another code point.
// depends on utf8d_pkg and utf8_stream_decoder_unit_assert.svh
`default_nettype none

`include "utf8_stream_decoder_unit_assert.svh"

module utf8_stream_decoder_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire utf8d_pkg::byte_t      s_tdata,   // [7:0] in_byte
  input  wire logic                  s_tlast,   // end_of_buffer
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output utf8d_pkg::out_data_t       m_tdata,   // [20:0] code_point, [23:21] seq_bytes
  output logic                       m_tlast    // last_point
);

  import utf8d_pkg::*;

  // input register
  logic  in_valid;
  byte_t in_byte;
  logic  in_eob;

  // decoder state
  len_t       exp_len;
  logic [1:0] held_count;
  byte_t      held_bytes [3];

  // decode
  logic       lead;
  len_t       need;
  logic [1:0] hc;
  len_t       cnt_raw;
  len_t       count;
  logic [1:0] last_idx;
  byte_t      seq0, seq1, seq2;
  cp_t        cp;
  logic       emit;
  logic       s1_go;

  always_comb begin
    lead     = (exp_len == LEN_NONE) || (held_count == 2'd0) || (exp_len > LEN4);
    need     = lead ? lead_length(in_byte) : exp_len;
    hc       = lead ? 2'd0 : held_count;
    cnt_raw  = {1'b0, hc} + LEN1;
    count    = (cnt_raw > need) ? need : cnt_raw;
    last_idx = count[1:0] - 2'd1;
    seq0     = (last_idx == 2'd0) ? in_byte : held_bytes[0];
    seq1     = (last_idx == 2'd1) ? in_byte : held_bytes[1];
    seq2     = (last_idx == 2'd2) ? in_byte : held_bytes[2];
    cp       = decode_seq(seq0, seq1, seq2, in_byte, count);
    emit     = (count == need) || in_eob;
  end

  assign s1_go    = in_valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eob  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len    <= LEN_NONE;
      held_count <= 2'd0;
    end else if (s1_go) begin
      if (emit) begin
        exp_len    <= LEN_NONE;
        held_count <= 2'd0;
      end else begin
        exp_len    <= need;
        held_count <= count[1:0];
      end
    end
  end

  // no reset: an entry is read only after being written in the same sequence
  always_ff @(posedge clk) begin
    if (s1_go && !emit) begin
      held_bytes[last_idx] <= in_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      m_tdata <= {count, cp};
      m_tlast <= in_eob;
    end
  end

  `UTF8D_ASSERT_IMP(a_state_pair, 1'b1, (exp_len == LEN_NONE) == (held_count == 2'd0))
  `UTF8D_ASSERT_IMP(a_pending_len, exp_len != LEN_NONE, ({1'b0, held_count} < exp_len) && (exp_len >= LEN2) && (exp_len <= LEN4))
  `UTF8D_ASSERT_NXT(a_eob_clears, s1_go && in_eob, exp_len == LEN_NONE)
  `UTF8D_ASSERT_NXT(a_emit_loads, s1_go && emit, m_tvalid)
  `UTF8D_ASSERT_IMP(a_out_len, m_tvalid, (m_tdata[23:21] >= LEN1) && (m_tdata[23:21] <= LEN4))

endmodule

`default_nettype wire
